// ===== src/sha1_pkg.sv =====
// SHA-1 stream hasher: shared types and constants.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sha1_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_FINISH
    } sha1_state_t;

    // Source of a byte pushed into the block buffer
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } sha1_src_t;

    typedef struct packed {
        logic      push;
        sha1_src_t src;
        logic      count_inc;
        logic      comp_start;
        logic      round_step;
        logic      fold;
        logic      finish;
    } sha1_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_len;
        logic round_last;
        logic out_busy;
    } sha1_stat_t;

    localparam int unsigned HWORDS = 5;

    localparam logic [HWORDS-1:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] POS_LEN    = 6'd56;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [6:0] ROUND_B1   = 7'd20;
    localparam logic [6:0] ROUND_B2   = 7'd40;
    localparam logic [6:0] ROUND_B3   = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

endpackage

`default_nettype wire

// ===== src/sha1_byte_if.sv =====
// Input channel of the SHA-1 stream hasher: at most one message byte per item.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface sha1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       final_item;

    modport source (output valid, output data_byte, output byte_valid,
                    output final_item, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input final_item, output ready);
endinterface

`default_nettype wire

// ===== src/sha1_digest_if.sv =====
// Output channel of the SHA-1 stream hasher: one digest word per item.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        word_last;

    modport source (output valid, output digest_word, output word_last, input ready);
    modport sink   (input valid, input digest_word, input word_last, output ready);
endinterface

`default_nettype wire

// ===== src/sha1_ctrl.sv =====
// SHA-1 controller: sequences byte intake, padding, compression and digest hand-off.
// Depends on sha1_pkg.
`default_nettype none

module sha1_ctrl
    import sha1_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       byte_valid,
    input  wire logic       final_item,
    output logic            in_ready,
    input  wire sha1_stat_t stat,
    output sha1_cmd_t       cmd
);

    sha1_state_t state_reg, state_next;
    sha1_state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.push      = 1'b1;
                        cmd.src       = SRC_DATA;
                        cmd.count_inc = 1'b1;
                    end
                    if (byte_valid && stat.pos_last)
                    begin
                        cmd.comp_start = 1'b1;
                        state_next     = ST_COMP;
                        ret_next       = final_item ? ST_PAD80 : ST_IDLE;
                    end
                    else if (final_item)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                cmd.push = 1'b1;
                cmd.src  = SRC_PAD;
                if (stat.pos_last)
                begin
                    cmd.comp_start = 1'b1;
                    state_next     = ST_COMP;
                    ret_next       = ST_ZERO;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (stat.pos_len)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.push = 1'b1;
                    cmd.src  = SRC_ZERO;
                    if (stat.pos_last)
                    begin
                        cmd.comp_start = 1'b1;
                        state_next     = ST_COMP;
                        ret_next       = ST_ZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.push = 1'b1;
                cmd.src  = SRC_LEN;
                if (stat.pos_last)
                begin
                    cmd.comp_start = 1'b1;
                    state_next     = ST_COMP;
                    ret_next       = ST_FINISH;
                end
            end
            ST_COMP:
            begin
                cmd.round_step = 1'b1;
                if (stat.round_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            ST_FINISH:
            begin
                // hold until the previous digest has drained
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sha1_dp.sv =====
// SHA-1 datapath: byte packing, message schedule, round unit, chaining words,
// byte count and the digest output buffer. Depends on sha1_pkg.
`default_nettype none

module sha1_dp
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire sha1_cmd_t   cmd,
    output sha1_stat_t       stat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic             word_last
);

    logic [31:0] w_reg [16];
    logic [23:0] acc_reg;
    logic [5:0]  pos_reg;
    logic [60:0] count_reg;
    logic [31:0] h_reg [HWORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  round_reg;
    logic [31:0] obuf_reg [HWORDS];
    logic [2:0]  ocnt_reg;

    logic [7:0]  push_byte;
    logic [63:0] bit_len;
    logic [31:0] f_val, k_val, t_val, w_mix, w_new;
    logic        out_take;

    assign bit_len = {count_reg, 3'b000};

    always_comb
    begin
        case (cmd.src)
            SRC_DATA: push_byte = data_byte;
            SRC_PAD:  push_byte = PAD_BYTE;
            SRC_ZERO: push_byte = 8'h00;
            SRC_LEN:  push_byte = 8'(bit_len >> {~pos_reg[2:0], 3'b000});
            default:  push_byte = 8'h00;
        endcase
    end

    // round function and constant by round group
    always_comb
    begin
        if (round_reg < ROUND_B1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < ROUND_B2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < ROUND_B3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    assign w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign out_take = out_valid && out_ready;

    // schedule window: word 0 is the current round's word
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            acc_reg <= {acc_reg[15:0], push_byte};
        end
        if (cmd.push && (pos_reg[1:0] == 2'b11))
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= {acc_reg, push_byte};
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round_step)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            round_reg <= '0;
            for (int i = 0; i < HWORDS; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            if (cmd.push)
            begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.finish)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.comp_start)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_step)
            begin
                round_reg <= round_reg + 7'd1;
            end
            if (cmd.fold)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            else if (cmd.finish)
            begin
                for (int i = 0; i < HWORDS; i++)
                begin
                    h_reg[i] <= H_INIT[i];
                end
            end
        end
    end

    // digest buffer: shift toward word 0 as items leave
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            for (int i = 0; i < HWORDS; i++)
            begin
                obuf_reg[i] <= h_reg[i];
            end
        end
        else if (out_take)
        begin
            for (int i = 0; i < HWORDS - 1; i++)
            begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
        end
        else if (cmd.finish)
        begin
            ocnt_reg <= 3'(HWORDS);
        end
        else if (out_take)
        begin
            ocnt_reg <= ocnt_reg - 3'd1;
        end
    end

    assign out_valid   = (ocnt_reg != 3'd0);
    assign digest_word = obuf_reg[0];
    assign word_last   = (ocnt_reg == 3'd1);

    assign stat.pos_last   = (pos_reg == POS_LAST);
    assign stat.pos_len    = (pos_reg == POS_LEN);
    assign stat.round_last = (round_reg == ROUND_LAST);
    assign stat.out_busy   = out_valid;

endmodule

`default_nettype wire

// ===== src/sha1_stream_hasher.sv =====
// SHA-1 stream hasher, top level. The item that fills a 64-byte block starts 80 rounds
// on one round unit, then the chaining add; no item is taken meanwhile. A final item
// pads one byte per cycle, paused while a block compresses, up to byte 56, then after
// an idle step sends 8 length bytes and compresses (one extra block when 0x80 lands at
// byte 56 or later); a finish step, held while an earlier digest drains, loads the
// words, the first one offered next. Reset: initial chaining words, counts zero.
`default_nettype none

module sha1_stream_hasher
    import sha1_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    sha1_byte_if.sink     msg,
    sha1_digest_if.source digest
);

    sha1_cmd_t  cmd;
    sha1_stat_t stat;

    // Controller: takes items, walks padding, runs the round counter via commands.
    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (msg.valid),
        .byte_valid (msg.byte_valid),
        .final_item (msg.final_item),
        .in_ready   (msg.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath: block buffer, round unit, chaining words and the digest buffer.
    // The digest buffer parts the output side, so a new message can be taken
    // while the previous digest still drains.
    sha1_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (msg.data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (digest.valid),
        .out_ready   (digest.ready),
        .digest_word (digest.digest_word),
        .word_last   (digest.word_last)
    );

endmodule

`default_nettype wire

// ===== tb/tb_sha1_stream_hasher.sv =====
// Self-checking testbench for sha1_stream_hasher: random and directed messages in,
// digest words out, checked against an in-bench SHA-1 scoreboard.
// Depends on sha1_stream_hasher, sha1_byte_if and sha1_digest_if from the RTL.
`default_nettype none

module tb_sha1_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    // SHA-1 initial chaining words and round constants, kept apart from the RTL copies
    localparam logic [31:0] IV_WORDS [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] RK_00_19 = 32'h5a827999;
    localparam logic [31:0] RK_20_39 = 32'h6ed9eba1;
    localparam logic [31:0] RK_40_59 = 32'h8f1bbcdc;
    localparam logic [31:0] RK_60_79 = 32'hca62c1d6;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_SLOT = 6'd56;
    localparam logic [5:0]  BLOCK_END = 6'd63;

    // Byte and final items to send, directed ones included; ignored items come on top
    localparam int unsigned MESSAGE_ITEMS = 310;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    // Worst final item: padding up to byte 56, 8 length bytes, two compressions
    localparam int unsigned DRAIN_CYCLES = 300;

    // Running SHA-1 of the message so far; queues five digest words per final item.
    class sha1_digest_scoreboard;
        typedef struct packed {
            logic [31:0] word;
            logic        last;
        } digest_word_t;

        logic [31:0]  chain [5];
        logic [31:0]  msg_words [16];
        logic [60:0]  byte_count;
        digest_word_t expected_words [$];
        int unsigned  mismatches;
        int unsigned  words_checked;
        int unsigned  messages;
        int unsigned  message_bytes;

        function new();
            mismatches = 0;
            words_checked = 0;
            messages = 0;
            message_bytes = 0;
            restart_message();
        endfunction

        function void restart_message();
            chain = IV_WORDS;
            foreach (msg_words[i])
                msg_words[i] = '0;
            byte_count = '0;
        endfunction

        function void compress_block();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, t, wr;
            w = msg_words;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++)
            begin
                if (r < 16)
                    wr = w[r];
                else
                begin
                    wr = w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15];
                    wr = {wr[30:0], wr[31]};
                    w[r & 15] = wr;
                end
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = RK_00_19;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = RK_20_39;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = RK_40_59;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = RK_60_79;
                end
                t = {a[26:0], a[31:27]} + f + e + k + wr;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // The first byte of a word clears the rest of it
        function void place_byte(logic [5:0] pos, logic [7:0] value);
            logic [31:0] lane;
            lane = {24'd0, value} << {~pos[1:0], 3'b000};
            if (pos[1:0] == 2'd0)
                msg_words[pos[5:2]] = lane;
            else
                msg_words[pos[5:2]] |= lane;
        endfunction

        function void take_item(logic [7:0] value, logic has_byte, logic is_final);
            logic [5:0]  pos;
            logic [63:0] bit_len;
            if (has_byte)
            begin
                pos = byte_count[5:0];
                place_byte(pos, value);
                byte_count++;
                message_bytes++;
                if (pos == BLOCK_END)
                    compress_block();
            end
            if (!is_final)
                return;
            pos = byte_count[5:0];
            place_byte(pos, PAD_MARK);
            for (int i = pos[5:2] + 1; i < 16; i++)
                msg_words[i] = '0;
            // No room for the length: flush this block and pad a fresh one
            if (pos >= LEN_SLOT)
            begin
                compress_block();
                foreach (msg_words[i])
                    msg_words[i] = '0;
            end
            bit_len = {byte_count, 3'b000};
            msg_words[14] = bit_len[63:32];
            msg_words[15] = bit_len[31:0];
            compress_block();
            for (int i = 0; i < 5; i++)
                expected_words.push_back('{word: chain[i], last: (i == 4)});
            messages++;
            restart_message();
        endfunction

        task report_mismatch(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_word(logic [31:0] word, logic last);
            digest_word_t want;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("digest word %08h with none pending", word));
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (word !== want.word)
                report_mismatch($sformatf("digest_word %08h, want %08h", word, want.word));
            if (last !== want.last)
                report_mismatch($sformatf("word_last %0b, want %0b (word %08h)",
                                          last, want.last, want.word));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int unsigned real_items;

    sha1_byte_if   msg_if();
    sha1_digest_if digest_if();

    sha1_digest_scoreboard sb = new();

    sha1_stream_hasher dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if.sink),
        .digest(digest_if.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    // Quiet stretches run with no gaps at all.
    function automatic int unsigned idle_cycles();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item after a random gap, hold it until accepted, then log it.
    // Called right after a rising edge; leaves valid high for a back-to-back item.
    task automatic send_item(input logic [7:0] value, input logic has_byte,
                             input logic is_final);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid      <= 1'b1;
        msg_if.data_byte  <= value;
        msg_if.byte_valid <= has_byte;
        msg_if.final_item <= is_final;
        do
            @(posedge clk);
        while (!msg_if.ready);
        sb.take_item(value, has_byte, is_final);
        if (has_byte || is_final)
            real_items++;
    endtask

    // Digest side: check each accepted word, then pick the next ready level.
    initial
    begin : digest_sink
        int unsigned hold;
        hold = 0;
        digest_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (digest_if.valid && digest_if.ready)
                sb.check_word(digest_if.digest_word, digest_if.word_last);
            if (hold > 0)
            begin
                digest_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                digest_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = idle_cycles();
            end
        end
    end

    initial
    begin : stimulus
        int unsigned msg_len;
        int unsigned pick;
        bit          tail_byte;

        real_items = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        msg_if.valid      <= 1'b0;
        msg_if.data_byte  <= 8'h00;
        msg_if.byte_valid <= 1'b0;
        msg_if.final_item <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, an ignored item, one-byte messages at the byte
        // extremes, "abc" ended by a byteless final, a byte on the final item,
        // and two empty messages back to back.
        send_item(8'ha5, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h3c, 1'b0, 1'b1);

        // Random messages. Lengths lean toward the padding boundaries (55/56,
        // 63/64, 119/120) and short messages, with a few spanning two blocks.
        // Sprinkle ignored items in between; trim the last message to the budget.
        while (real_items < MESSAGE_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                msg_len = $urandom_range(0, 8);
            else if (pick < 7)
                msg_len = $urandom_range(52, 72);
            else if (pick < 9)
                msg_len = $urandom_range(1, 40);
            else
                msg_len = $urandom_range(100, 140);
            if (msg_len > MESSAGE_ITEMS - real_items)
                msg_len = MESSAGE_ITEMS - real_items;
            tail_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < msg_len; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          tail_byte && (i == msg_len - 1));
            end
            if (!tail_byte)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        msg_if.valid <= 1'b0;
        quiet = 1'b0;

        // Drain: wait for every digest word, then give the block time to misbehave
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages (%0d bytes, %0d items), %0d digest words checked.",
                 sb.messages, sb.message_bytes, real_items, sb.words_checked);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d digest words still pending",
                 cycles, sb.expected_words.size());
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
